// ===== hdl/fvid_pkg.sv =====
// Shared constants and types for the flux interval decoder.
package fvid_pkg;

	localparam logic [7:0]  EXTEND_MIN    = 8'd250;
	localparam logic [7:0]  LONG_MARK     = 8'd255;
	localparam logic [29:0] NS_PER_SECOND = 30'd1000000000;
	localparam logic [31:0] FREQ_RESET    = 32'd72000000;

	localparam int PROD_W    = 62;
	localparam int DIV_STEPS = PROD_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// long value byte phase codes
	localparam logic [2:0] PH_NORMAL = 3'd0;
	localparam logic [2:0] PH_FIRST  = 3'd1;
	localparam logic [2:0] PH_LAST   = 3'd4;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_DONE
	} fvid_state_t;

endpackage

// ===== hdl/fvid_if.sv =====
// Valid/ready channels carrying flux stream bytes and decoded intervals.
interface fvid_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] raw_byte;
	logic       stream_end;

	modport source (output valid, output raw_byte, output stream_end, input ready);
	modport sink   (input valid, input raw_byte, input stream_end, output ready);
endinterface

interface fvid_interval_if;
	logic        valid;
	logic        ready;
	logic [31:0] interval_ns;
	logic        track_end;

	modport source (output valid, output interval_ns, output track_end, input ready);
	modport sink   (input valid, input interval_ns, input track_end, output ready);
endinterface

// ===== hdl/flux_varlen_interval_decoder.sv =====
// A word that closes a nonzero value gives its interval through ST_MUL, ST_DIV and ST_DONE;
// other words are decoded in ST_IDLE, and an end-of-track word appears in the next cycle.
// Flow: one word a cycle while the output register is free, until a nonzero value closes;
// then none is taken until the multiply and the 62-step shared restoring divider are done.
// Reset: arst_n clears the decode state and the output valid flag and loads
// the sample frequency with 72 MHz.
module flux_varlen_interval_decoder
	import fvid_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [31:0]             cfg_wdata,
	fvid_byte_if.sink               flux,
	fvid_interval_if.source         interval
);

	fvid_state_t state_q, state_d;

	logic [31:0]       acc_q, acc_d;
	logic [2:0]        phase_q, phase_d;
	logic [31:0]       freq_q;
	logic [PROD_W-1:0] dq_q;
	logic [31:0]       rem_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [31:0]       out_ns_q;
	logic              out_end_q;

	logic        accept;
	logic        out_free;
	logic        in_ready;
	logic        long_active;
	logic [4:0]  shift_amt;
	logic [31:0] addend;
	logic [31:0] sum;
	logic        fin;
	logic        emit_end;
	logic        start_div;
	logic        load_div;
	logic [32:0] partial;
	logic [32:0] trial;
	logic        ge;
	logic [PROD_W-1:0] product;

	assign out_free    = !out_valid_q || interval.ready;
	assign accept      = flux.valid && in_ready;
	assign flux.ready  = in_ready;

	assign long_active = (phase_q >= PH_FIRST) && (phase_q <= PH_LAST);
	assign shift_amt   = {phase_q[1:0] - 2'd1, 3'b000};
	assign addend      = long_active ? ({24'd0, flux.raw_byte} << shift_amt)
	                                 : {24'd0, flux.raw_byte};
	assign sum         = acc_q + addend;

	// word decode
	always_comb begin
		acc_d    = acc_q;
		phase_d  = phase_q;
		fin      = 1'b0;
		emit_end = 1'b0;
		if (flux.stream_end) begin
			acc_d    = '0;
			phase_d  = PH_NORMAL;
			emit_end = 1'b1;
		end else if (long_active) begin
			if (phase_q == PH_LAST) begin
				fin     = 1'b1;
				acc_d   = '0;
				phase_d = PH_NORMAL;
			end else begin
				acc_d   = sum;
				phase_d = phase_q + 3'd1;
			end
		end else begin
			phase_d = PH_NORMAL;
			if (flux.raw_byte < EXTEND_MIN) begin
				fin   = 1'b1;
				acc_d = '0;
			end else if (flux.raw_byte == LONG_MARK) begin
				phase_d = PH_FIRST;
			end else begin
				acc_d = sum;
			end
		end
		if (fin && sum == 32'd0) begin
			emit_end = 1'b1;
		end
	end

	assign start_div = fin && (sum != 32'd0);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		load_div = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = out_free;
				if (accept && start_div) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: begin
				state_d = ST_DIV;
			end
			ST_DIV: begin
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_div = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// shared divider step: one trial subtract per cycle
	assign partial = {rem_q, dq_q[PROD_W-1]};
	assign trial   = partial - {1'b0, freq_q};
	assign ge      = !trial[32];
	assign product = {30'd0, dq_q[31:0]} * {32'd0, NS_PER_SECOND};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			phase_q <= PH_NORMAL;
			freq_q  <= FREQ_RESET;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				acc_q   <= acc_d;
				phase_q <= phase_d;
			end
			// drop zero writes
			if (cfg_we && cfg_wdata != 32'd0) begin
				freq_q <= cfg_wdata;
			end
			if (state_q == ST_MUL) begin
				cnt_q <= '0;
			end else if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && start_div) begin
			dq_q <= {30'd0, sum};
		end else if (state_q == ST_MUL) begin
			dq_q  <= product;
			rem_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? trial[31:0] : partial[31:0];
			dq_q  <= {dq_q[PROD_W-2:0], ge};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((accept && emit_end) || load_div) begin
			out_valid_q <= 1'b1;
		end else if (interval.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit_end) begin
			out_ns_q  <= '0;
			out_end_q <= 1'b1;
		end else if (load_div) begin
			out_ns_q  <= dq_q[31:0];
			out_end_q <= 1'b0;
		end
	end

	assign interval.valid       = out_valid_q;
	assign interval.interval_ns = out_ns_q;
	assign interval.track_end   = out_end_q;

	a_ready_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		flux.ready |-> state_q == ST_IDLE)
		else $error("input ready outside idle");

	a_mul_then_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MUL |=> state_q == ST_DIV && cnt_q == '0)
		else $error("divider not started after multiply");

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q <= PH_LAST)
		else $error("long value phase out of range");

	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(flux.valid && flux.ready) || $past(state_q == ST_DONE))
		else $error("result appeared without a source");

	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
		else $error("divider step count overrun");

endmodule

// ===== bench/flux_varlen_interval_decoder_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the flux interval decoder: directed table, then random streams.
module flux_varlen_interval_decoder_tb
	import fvid_pkg::*;
();

	localparam int WORDS_PER_PHASE = 250;
	localparam int SETTLE_CYCLES   = 80;
	localparam int BACKLOG_CYCLES  = 400;
	localparam int CYCLE_LIMIT     = 2000000;
	localparam int N_PHASES        = 8;
	localparam int N_ROWS          = 24;

	typedef struct packed {
		logic [31:0] ns;
		logic        te;
	} interval_t;

	typedef struct packed {
		logic [7:0]  raw_byte;
		logic        stream_end;
		logic        fixed;
		logic [31:0] fixed_ns;
		logic        fixed_te;
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [31:0] cfg_wdata;

	fvid_byte_if     flux_ch ();
	fvid_interval_if ivl_ch ();

	flux_varlen_interval_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.flux      (flux_ch),
		.interval  (ivl_ch)
	);

	// decoder state as the bench sees it
	logic [31:0] freq_hz;
	logic [31:0] tick_sum;
	logic [2:0]  long_phase;
	logic [31:0] long_shift;

	interval_t pending_intervals [$];
	int        fail_count;
	int        cycle_count;
	int        words_sent;
	logic      gaps_on;
	logic      backlog_hold;
	stim_row_t directed_rows [0:N_ROWS-1];
	logic [31:0] phase_freq [0:N_PHASES-1];

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("flux_varlen_interval_decoder test failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what);
		$display("MISMATCH cycle %0d: %s", cycle_count, what);
		fail_count++;
	endtask

	// Advance the decode state by one word; returns 1 when the word gives an output word (an interval or a track end).
	function automatic logic predict_interval(input logic [7:0] b, input logic se,
			output interval_t res);
		logic        closes;
		logic [31:0] ticks;
		closes = 1'b0;
		res = '0;
		if (se) begin
			tick_sum = '0;
			long_phase = PH_NORMAL;
			long_shift = '0;
			res.te = 1'b1;
			return 1'b1;
		end
		if (long_phase >= PH_FIRST && long_phase <= PH_LAST) begin
			tick_sum = tick_sum + ({24'd0, b} << long_shift[4:0]);
			long_shift = long_shift + 32'd8;
			if (long_phase == PH_LAST)
				closes = 1'b1;
			else
				long_phase = long_phase + 3'd1;
		end else begin
			long_phase = PH_NORMAL;
			if (b < EXTEND_MIN) begin
				tick_sum = tick_sum + {24'd0, b};
				closes = 1'b1;
			end else if (b == LONG_MARK) begin
				long_phase = PH_FIRST;
				long_shift = '0;
			end else begin
				tick_sum = tick_sum + {24'd0, b};
			end
		end
		if (!closes)
			return 1'b0;
		ticks = tick_sum;
		tick_sum = '0;
		long_phase = PH_NORMAL;
		long_shift = '0;
		if (ticks == 0)
			res.te = 1'b1;
		else
			res.ns = 32'((64'(ticks) * 64'(NS_PER_SECOND)) / 64'(freq_hz));
		return 1'b1;
	endfunction

	task automatic send_word(input logic [7:0] b, input logic se, input logic use_fixed,
			input interval_t fixed_res);
		int        gap;
		int        r;
		logic      gives;
		interval_t res;
		gap = 0;
		if (gaps_on) begin
			r = $urandom_range(0, 99);
			if (r >= 95)
				gap = $urandom_range(20, 80);
			else if (r >= 70)
				gap = $urandom_range(1, 3);
		end
		if (gap > 0) begin
			flux_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		flux_ch.valid <= 1'b1;
		flux_ch.raw_byte <= b;
		flux_ch.stream_end <= se;
		@(posedge clk);
		while (!flux_ch.ready) @(posedge clk);
		words_sent++;
		gives = predict_interval(b, se, res);
		if (use_fixed)
			pending_intervals.push_back(fixed_res);
		else if (gives)
			pending_intervals.push_back(res);
	endtask

	// One value of random content: a stream end, or extension bytes then a short or long close.
	task automatic send_value();
		int kind;
		int n_ext;
		int cut;
		kind = $urandom_range(0, 19);
		if (kind == 0) begin
			send_word(8'($urandom), 1'b1, 1'b0, '0);
			return;
		end
		n_ext = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		for (int i = 0; i < n_ext; i++)
			send_word(8'($urandom_range(EXTEND_MIN, LONG_MARK - 1)), 1'b0, 1'b0, '0);
		if (kind <= 4) begin
			// now and then cut a long value short with a stream end
			cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 3) : 4;
			send_word(LONG_MARK, 1'b0, 1'b0, '0);
			for (int i = 0; i < cut; i++)
				send_word(8'($urandom), 1'b0, 1'b0, '0);
			if (cut < 4)
				send_word(8'($urandom), 1'b1, 1'b0, '0);
		end else if (kind <= 6) begin
			send_word(8'd0, 1'b0, 1'b0, '0);
		end else begin
			send_word(8'($urandom_range(0, EXTEND_MIN - 1)), 1'b0, 1'b0, '0);
		end
	endtask

	task automatic drain_and_settle();
		flux_ch.valid <= 1'b0;
		while (pending_intervals.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_freq(input logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		// a zero divisor is refused by the block
		if (v != 0)
			freq_hz = v;
	endtask

	// result side: random stalls, and one long hold-off on request
	initial begin : sink_side
		int stall_left;
		int burst_left;
		int r;
		stall_left = 0;
		burst_left = 0;
		ivl_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (backlog_hold) begin
				backlog_hold = 1'b0;
				stall_left = BACKLOG_CYCLES;
				burst_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				ivl_ch.ready <= 1'b0;
			end else if (burst_left > 0) begin
				burst_left--;
				ivl_ch.ready <= 1'b1;
			end else begin
				r = $urandom_range(0, 9);
				if (r <= 5) begin
					burst_left = $urandom_range(0, 30);
					ivl_ch.ready <= 1'b1;
				end else if (r <= 8) begin
					stall_left = $urandom_range(0, 3);
					ivl_ch.ready <= 1'b0;
				end else begin
					stall_left = $urandom_range(20, 120);
					ivl_ch.ready <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : check_side
		interval_t want;
		if (arst_n && ivl_ch.valid && ivl_ch.ready) begin
			if (pending_intervals.size() == 0) begin
				report_mismatch($sformatf("unexpected word ns=%0d te=%0b",
					ivl_ch.interval_ns, ivl_ch.track_end));
			end else begin
				want = pending_intervals.pop_front();
				if (ivl_ch.interval_ns !== want.ns)
					report_mismatch($sformatf("interval_ns %0d, want %0d",
						ivl_ch.interval_ns, want.ns));
				if (ivl_ch.track_end !== want.te)
					report_mismatch($sformatf("track_end %0b, want %0b",
						ivl_ch.track_end, want.te));
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		flux_ch.valid = 1'b0;
		flux_ch.raw_byte = '0;
		flux_ch.stream_end = 1'b0;
		fail_count = 0;
		cycle_count = 0;
		words_sent = 0;
		gaps_on = 1'b1;
		backlog_hold = 1'b0;
		freq_hz = FREQ_RESET;
		tick_sum = '0;
		long_phase = PH_NORMAL;
		long_shift = '0;

		// byte, end, fixed, ns, track_end
		directed_rows = '{
			'{8'h00, 1'b0, 1'b1, 32'd0,  1'b1},
			'{8'h01, 1'b0, 1'b1, 32'd13, 1'b0},
			'{8'hF9, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFA, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFE, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFA, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b1, 1'b1, 32'd0,  1'b1},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b0, 1'b1, 32'd0,  1'b1},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h01, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h02, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'h00, 1'b1, 1'b1, 32'd0,  1'b1},
			'{8'h05, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFA, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0},
			'{8'hFF, 1'b0, 1'b0, 32'd0,  1'b0}
		};
		// the zero write follows the slowest setting and must leave it in place
		phase_freq = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd250000,
			32'd0, 32'd80000000, 32'd0, 32'd0};
		phase_freq[4] = $urandom_range(1, 1000000);
		phase_freq[6] = $urandom();
		phase_freq[7] = $urandom();

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_ROWS; i++)
			send_word(directed_rows[i].raw_byte, directed_rows[i].stream_end,
				directed_rows[i].fixed,
				{directed_rows[i].fixed_ns, directed_rows[i].fixed_te});

		for (int p = 0; p < N_PHASES; p++) begin
			drain_and_settle();
			write_freq(phase_freq[p]);
			// no sender gaps in one phase, and a receiver hold-off in another
			gaps_on = (p != 3);
			if (p == 2)
				backlog_hold = 1'b1;
			words_sent = 0;
			while (words_sent < WORDS_PER_PHASE)
				send_value();
		end

		drain_and_settle();
		if (fail_count == 0)
			$display("flux_varlen_interval_decoder test passed");
		else
			$display("flux_varlen_interval_decoder test failed");
		$finish;
	end

endmodule

// ===== flux_varlen_interval_decoder.f =====
hdl/fvid_pkg.sv
hdl/fvid_if.sv
hdl/flux_varlen_interval_decoder.sv
bench/flux_varlen_interval_decoder_tb.sv
